// ----- rtl/usbpa_pkg.sv -----
// Shared types, PID tables and CRC16 helpers for the USB packet assembler.
package usbpa_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8005;

  localparam logic [7:0] PID_ACK   = 8'hD2;
  localparam logic [7:0] PID_NAK   = 8'h5A;
  localparam logic [7:0] PID_STALL = 8'h1E;
  localparam logic [7:0] PID_NYET  = 8'h96;
  localparam logic [7:0] PID_DATA0 = 8'hC3;
  localparam logic [7:0] PID_DATA1 = 8'h4B;
  localparam logic [7:0] PID_DATA2 = 8'h87;
  localparam logic [7:0] PID_MDATA = 8'h0F;

  localparam logic [1:0] TOK_ACK   = 2'd0;
  localparam logic [1:0] TOK_NAK   = 2'd1;
  localparam logic [1:0] TOK_STALL = 2'd2;
  localparam logic [1:0] TOK_NYET  = 2'd3;
  localparam logic [1:0] DAT_DATA0 = 2'd0;
  localparam logic [1:0] DAT_DATA1 = 2'd1;
  localparam logic [1:0] DAT_DATA2 = 2'd2;
  localparam logic [1:0] DAT_MDATA = 2'd3;

  typedef struct packed {
    logic       tok_req;
    logic [1:0] tok_sel;
    logic       pkt_req;
    logic [1:0] pkt_sel;
    logic [7:0] data_byte;
    logic       endpoint_empty;
    logic       phy_ready;
  } in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       phy_valid;
    logic       phy_last;
    logic       phy_first;
    logic       read_next;
  } out_t;

  // CRC register control from the sequencer
  typedef struct packed {
    logic       clr;
    logic       add;
    logic [7:0] data;
  } crc_ctl_t;

  function automatic logic [7:0] tok_code(input logic [1:0] sel);
    logic [7:0] pid;
    unique case (sel)
      TOK_ACK:   pid = PID_ACK;
      TOK_NAK:   pid = PID_NAK;
      TOK_STALL: pid = PID_STALL;
      TOK_NYET:  pid = PID_NYET;
      default:   pid = PID_ACK;
    endcase
    return pid;
  endfunction

  function automatic logic [7:0] pkt_code(input logic [1:0] sel);
    logic [7:0] pid;
    unique case (sel)
      DAT_DATA0: pid = PID_DATA0;
      DAT_DATA1: pid = PID_DATA1;
      DAT_DATA2: pid = PID_DATA2;
      DAT_MDATA: pid = PID_MDATA;
      default:   pid = PID_DATA0;
    endcase
    return pid;
  endfunction

  function automatic logic [7:0] bit_rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

  // advance the CRC over one byte, least significant bit first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[15] ^ d[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/usb_packet_assembler.sv -----
// Top level of the USB device transmit packet assembler.
//
// Each input word is one cycle of the transmit interface: token and data
// requests, PID selects, the current payload byte, the empty flag and the
// PHY ready strobe. Each accepted word yields exactly one result word: the
// byte and valid registers toward the PHY, the last-byte and first-cycle
// flags and the read_next payload fetch strobe.
//
// The result word of an accepted input word is registered and held in
// out_data from the next cycle until taken. Throughput is one word per
// cycle while out_ready holds; the sequencer state advances once per
// accepted word, so the single result register sets the rate.
//
// While the receiver stalls, the result register holds and in_ready drops,
// so no state moves. in_ready returns in the cycle out_ready rises again.
//
// Reset (rst_n low at a clock edge) returns the FSM to idle, clears all
// flags and the byte register and empties the result register. The CRC
// register is loaded at the start of every data packet and needs no reset.
module usb_packet_assembler (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  usbpa_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output usbpa_pkg::out_t out_data
);
  import usbpa_pkg::*;

  logic     adv;
  crc_ctl_t crc_ctl;
  logic [15:0] crc;
  out_t     res;
  logic     out_valid_r;
  out_t     out_data_r;

  // take a word whenever the result register is free or being drained
  assign in_ready = ~out_valid_r | out_ready;
  assign adv      = in_valid & in_ready;

  usbpa_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .item    (in_data),
    .crc     (crc),
    .crc_ctl (crc_ctl),
    .res     (res)
  );

  usbpa_crc u_crc (
    .clk   (clk),
    .ctl   (crc_ctl),
    .crc_r (crc)
  );

  // result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result register not empty after reset");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

  a_token_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.tok_req |=> out_data.phy_last)
    else $error("token request without last-byte flag");

endmodule

// ----- rtl/usbpa_crc.sv -----
// CRC16 register: load on packet start, advance once per payload byte.
module usbpa_crc (
  input  logic                clk,
  input  usbpa_pkg::crc_ctl_t ctl,
  output logic [15:0]         crc_r
);
  import usbpa_pkg::*;

  logic [15:0] crc_nxt;

  always_comb begin
    crc_nxt = crc_r;
    if (ctl.clr) begin
      crc_nxt = CRC_INIT;
    end else if (ctl.add) begin
      crc_nxt = crc16_byte(crc_r, ctl.data);
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
  end

endmodule

// ----- rtl/usbpa_seq.sv -----
// Packet sequencer: FSM, byte path and transmit flags for one cycle word.
module usbpa_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  usbpa_pkg::in_t      item,
  input  logic [15:0]         crc,
  output usbpa_pkg::crc_ctl_t crc_ctl,
  output usbpa_pkg::out_t     res
);
  import usbpa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DATA,
    ST_CRC1,
    ST_CRC2
  } state_t;

  state_t     state_r, state_nxt;
  logic       zero_len_r, zero_len_nxt;
  logic       tok_pend_r, tok_pend_nxt;
  logic       vd1_r, vd2_r, valid_out_r, valid_nxt;
  logic [7:0] byte_out_r, byte_nxt;
  logic       req_seen_r;
  logic       sd1_r, sd2_r;

  logic       dsel, rd, last, sel1, sel2;
  logic [7:0] spec, path;
  logic       clr, add;

  always_comb begin
    valid_nxt = 1'b0;
    dsel      = 1'b0;
    rd        = 1'b0;
    last      = 1'b0;
    sel1      = 1'b0;
    sel2      = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (item.pkt_req) begin
          valid_nxt = 1'b1;
          dsel      = 1'b1;
          state_nxt = item.endpoint_empty ? ST_CRC1 : ST_DATA;
        end
      end
      ST_DATA: begin
        rd        = item.phy_ready & vd2_r;
        valid_nxt = 1'b1;
        if (!item.pkt_req && item.phy_ready && vd2_r) begin
          dsel      = 1'b1;
          sel1      = 1'b1;
          state_nxt = ST_CRC1;
        end
      end
      ST_CRC1: begin
        dsel      = 1'b1;
        valid_nxt = 1'b1;
        if (item.phy_ready) begin
          last      = 1'b1;
          sel2      = 1'b1;
          state_nxt = ST_CRC2;
        end else begin
          sel1 = 1'b1;
        end
      end
      ST_CRC2: begin
        dsel = 1'b1;
        sel2 = 1'b1;
        if (item.phy_ready) begin
          state_nxt = ST_IDLE;
        end else begin
          last = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // CRC goes out complemented and bit-reversed, high byte first
  always_comb begin
    if (sel1) begin
      spec = bit_rev8(~crc[15:8]);
    end else if (sel2) begin
      spec = bit_rev8(~crc[7:0]);
    end else begin
      spec = pkt_code(item.pkt_sel);
    end
    path     = dsel ? spec : item.data_byte;
    // a token overrides the byte path without touching the FSM
    byte_nxt = (item.tok_req || tok_pend_r) ? tok_code(item.tok_sel) : path;
  end

  assign clr = item.pkt_req & ~sd1_r;
  assign add = ~zero_len_r & ((sd1_r & ~sd2_r) | (rd & ~sel1));

  always_comb begin
    zero_len_nxt = zero_len_r;
    if (last) begin
      zero_len_nxt = 1'b0;
    end else if (clr) begin
      zero_len_nxt = item.endpoint_empty;
    end
    tok_pend_nxt = tok_pend_r;
    if (item.tok_req) begin
      tok_pend_nxt = 1'b1;
    end else if (item.phy_ready) begin
      tok_pend_nxt = 1'b0;
    end
  end

  assign crc_ctl.clr  = adv & clr;
  assign crc_ctl.add  = adv & add;
  assign crc_ctl.data = item.data_byte;

  assign res.tx_byte   = byte_out_r;
  assign res.phy_valid = valid_out_r;
  assign res.phy_last  = item.tok_req | last;
  assign res.phy_first = (item.tok_req | item.pkt_req) & ~req_seen_r;
  assign res.read_next = rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      zero_len_r  <= 1'b0;
      tok_pend_r  <= 1'b0;
      vd1_r       <= 1'b0;
      vd2_r       <= 1'b0;
      valid_out_r <= 1'b0;
      byte_out_r  <= 8'h00;
      req_seen_r  <= 1'b0;
      sd1_r       <= 1'b0;
      sd2_r       <= 1'b0;
    end else if (adv) begin
      state_r     <= state_nxt;
      zero_len_r  <= zero_len_nxt;
      tok_pend_r  <= tok_pend_nxt;
      vd2_r       <= vd1_r;
      vd1_r       <= valid_out_r;
      valid_out_r <= valid_nxt;
      byte_out_r  <= byte_nxt;
      req_seen_r  <= item.tok_req | item.pkt_req;
      sd2_r       <= sd1_r;
      sd1_r       <= item.pkt_req;
    end
  end

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the USB transmit packet assembler.
`timescale 1ns / 1ps

module testbench;
  import usbpa_pkg::*;

  // Stop the run after this many cycles in which neither channel moves a word.
  localparam int STALL_LIMIT = 1000;
  // Settle time after the last expected word before the verdict.
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_WORDS = 1500;

  localparam logic [7:0] TOKEN_CODES [0:3] = '{PID_ACK, PID_NAK, PID_STALL, PID_NYET};
  localparam logic [7:0] DATA_CODES  [0:3] = '{PID_DATA0, PID_DATA1, PID_DATA2, PID_MDATA};

  typedef enum logic [1:0] {SEQ_IDLE, SEQ_PAYLOAD, SEQ_CRC_HI, SEQ_CRC_LO} seq_state_t;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  usb_packet_assembler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Words still to be offered, and PHY-side words the assembler owes us.
  in_t  stim_words[$];
  out_t tx_words_due[$];
  int   fault_count = 0;

  // Mirror of the assembler's registers, advanced once per accepted word.
  seq_state_t seq_state;
  logic [15:0] crc_acc;
  logic        zlp_flag;
  logic        token_hold;
  logic        valid_pipe1;
  logic        valid_pipe2;
  logic        phy_valid_q;
  logic [7:0]  tx_byte_q;
  logic        req_seen;
  logic        pkt_req_q1;
  logic        pkt_req_q2;

  // Fold one byte into the CRC16, least significant bit first.
  function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] octet);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[15] ^ octet[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  // Work out the PHY-side word of one cycle, then clock the mirrored registers.
  task automatic assemble_cycle(input in_t w, output out_t r);
    seq_state_t nxt;
    logic       load_valid, use_special, rd, last, pick_hi, pick_lo, clr, add;
    logic [7:0] crc_hi_inv, crc_lo_inv, special, path_byte, next_byte;
    nxt         = seq_state;
    load_valid  = 1'b0;
    use_special = 1'b0;
    rd          = 1'b0;
    last        = 1'b0;
    pick_hi     = 1'b0;
    pick_lo     = 1'b0;
    case (seq_state)
      SEQ_IDLE: begin
        if (w.pkt_req) begin
          load_valid  = 1'b1;
          use_special = 1'b1;
          nxt         = w.endpoint_empty ? SEQ_CRC_HI : SEQ_PAYLOAD;
        end
      end
      SEQ_PAYLOAD: begin
        rd         = w.phy_ready && valid_pipe2;
        load_valid = 1'b1;
        if (!w.pkt_req && rd) begin
          use_special = 1'b1;
          pick_hi     = 1'b1;
          nxt         = SEQ_CRC_HI;
        end
      end
      SEQ_CRC_HI: begin
        use_special = 1'b1;
        load_valid  = 1'b1;
        if (w.phy_ready) begin
          last    = 1'b1;
          pick_lo = 1'b1;
          nxt     = SEQ_CRC_LO;
        end else begin
          pick_hi = 1'b1;
        end
      end
      default: begin
        use_special = 1'b1;
        pick_lo     = 1'b1;
        if (w.phy_ready) begin
          nxt = SEQ_IDLE;
        end else begin
          last = 1'b1;
        end
      end
    endcase

    crc_hi_inv = ~crc_acc[15:8];
    crc_lo_inv = ~crc_acc[7:0];
    if (pick_hi) begin
      special = {<<{crc_hi_inv}};
    end else if (pick_lo) begin
      special = {<<{crc_lo_inv}};
    end else begin
      special = DATA_CODES[w.pkt_sel];
    end
    path_byte = use_special ? special : w.data_byte;
    // A token, fresh or still pending, wins over the packet byte path.
    next_byte = (w.tok_req || token_hold) ? TOKEN_CODES[w.tok_sel] : path_byte;

    clr = w.pkt_req && !pkt_req_q1;
    add = !zlp_flag && ((pkt_req_q1 && !pkt_req_q2) || (rd && !pick_hi));

    r.tx_byte   = tx_byte_q;
    r.phy_valid = phy_valid_q;
    r.phy_last  = w.tok_req || last;
    r.phy_first = (w.tok_req || w.pkt_req) && !req_seen;
    r.read_next = rd;

    if (last) begin
      zlp_flag = 1'b0;
    end else if (clr) begin
      zlp_flag = w.endpoint_empty;
    end
    valid_pipe2 = valid_pipe1;
    valid_pipe1 = phy_valid_q;
    phy_valid_q = load_valid;
    if (w.tok_req) begin
      token_hold = 1'b1;
    end else if (w.phy_ready) begin
      token_hold = 1'b0;
    end
    tx_byte_q  = next_byte;
    req_seen   = w.tok_req || w.pkt_req;
    pkt_req_q2 = pkt_req_q1;
    pkt_req_q1 = w.pkt_req;
    if (clr) begin
      crc_acc = CRC_INIT;
    end else if (add) begin
      crc_acc = crc16_fold(crc_acc, w.data_byte);
    end
    seq_state = nxt;
  endtask

  task automatic queue_word(input logic tok, input logic [1:0] tsel, input logic sd,
                            input logic [1:0] dsel, input logic [7:0] octet,
                            input logic empty, input logic rdy);
    in_t w;
    w.tok_req        = tok;
    w.tok_sel        = tsel;
    w.pkt_req        = sd;
    w.pkt_sel        = dsel;
    w.data_byte      = octet;
    w.endpoint_empty = empty;
    w.phy_ready      = rdy;
    stim_words.push_back(w);
  endtask

  task automatic compare_field(input string label, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      fault_count++;
    end
  endtask

  // Driver: offer the next word once the previous one has gone, after its gap.
  int src_gap  = 0;
  bit src_calm = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap = 0;
    end else if (!in_valid || in_ready) begin
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (stim_words.size() > 0) begin
        in_data  <= stim_words.pop_front();
        in_valid <= 1'b1;
        // Flip now and then between back-to-back runs and gappy runs.
        if ($urandom_range(0, 63) == 0) src_calm = !src_calm;
        src_gap = src_calm ? 0 : $urandom_range(0, 14);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result word against the oldest prediction first, then
  // predict for the input word taken at this edge, so the order never matters.
  int   sink_stall = 0;
  bit   sink_calm  = 1'b0;
  out_t due_word;
  out_t fresh_word;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready   <= 1'b0;
      sink_stall  = 0;
      seq_state   = SEQ_IDLE;
      crc_acc     = 16'h0000;
      zlp_flag    = 1'b0;
      token_hold  = 1'b0;
      valid_pipe1 = 1'b0;
      valid_pipe2 = 1'b0;
      phy_valid_q = 1'b0;
      tx_byte_q   = 8'h00;
      req_seen    = 1'b0;
      pkt_req_q1  = 1'b0;
      pkt_req_q2  = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (tx_words_due.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, out_data);
          fault_count++;
        end else begin
          due_word = tx_words_due.pop_front();
          compare_field("tx_byte", due_word.tx_byte, out_data.tx_byte);
          compare_field("phy_valid", due_word.phy_valid, out_data.phy_valid);
          compare_field("phy_last", due_word.phy_last, out_data.phy_last);
          compare_field("phy_first", due_word.phy_first, out_data.phy_first);
          compare_field("read_next", due_word.read_next, out_data.read_next);
        end
        if ($urandom_range(0, 63) == 0) sink_calm = !sink_calm;
        sink_stall = sink_calm ? 0 : $urandom_range(0, 14);
      end
      if (in_valid && in_ready) begin
        assemble_cycle(in_data, fresh_word);
        tx_words_due.push_back(fresh_word);
      end
      if (sink_stall > 0) begin
        sink_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: give up when both channels sit still for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int         target;
    int         len;
    int         kind;
    logic [1:0] pid_sel;
    logic       empty;
    logic [15:0] raw;

    // Directed part: every token, a token left pending into a packet start,
    // a zero-length packet with PHY stalls on both CRC bytes, and a payload
    // packet with extreme bytes and a token arriving mid-packet.
    queue_word(1'b1, TOK_ACK,   1'b0, DAT_DATA0, 8'h00, 1'b0, 1'b1);
    queue_word(1'b1, TOK_NAK,   1'b0, DAT_DATA0, 8'hFF, 1'b0, 1'b1);
    queue_word(1'b1, TOK_STALL, 1'b0, DAT_DATA0, 8'h00, 1'b0, 1'b1);
    queue_word(1'b1, TOK_NYET,  1'b0, DAT_DATA0, 8'hFF, 1'b0, 1'b0);
    queue_word(1'b0, TOK_NYET,  1'b0, DAT_DATA0, 8'h00, 1'b0, 1'b0);
    queue_word(1'b0, TOK_NYET,  1'b1, DAT_DATA0, 8'h00, 1'b1, 1'b1);
    queue_word(1'b0, TOK_ACK,   1'b0, DAT_DATA0, 8'h00, 1'b0, 1'b0);
    queue_word(1'b0, TOK_ACK,   1'b0, DAT_DATA0, 8'h00, 1'b0, 1'b1);
    queue_word(1'b0, TOK_ACK,   1'b0, DAT_DATA0, 8'h00, 1'b0, 1'b0);
    queue_word(1'b0, TOK_ACK,   1'b0, DAT_DATA0, 8'h00, 1'b0, 1'b1);
    queue_word(1'b0, TOK_ACK,   1'b0, DAT_DATA0, 8'h00, 1'b0, 1'b1);
    for (int i = 0; i < 6; i++) begin
      queue_word(i == 3, TOK_NYET, 1'b1, DAT_MDATA, (i % 2 == 0) ? 8'hFF : 8'h00, 1'b0, 1'b1);
    end
    for (int i = 0; i < 7; i++) begin
      queue_word(1'b0, TOK_ACK, 1'b0, DAT_MDATA, 8'hA5, 1'b0, 1'b1);
    end

    // Random part: mostly well-formed packets with random payload and PHY
    // pacing, some bare tokens and some words of pure noise.
    target = stim_words.size() + RANDOM_WORDS;
    while (stim_words.size() < target) begin
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        pid_sel = 2'($urandom_range(0, 3));
        empty   = ($urandom_range(0, 4) == 0);
        len     = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          queue_word($urandom_range(0, 19) == 0, 2'($urandom_range(0, 3)), 1'b1, pid_sel,
                     8'($urandom_range(0, 255)), empty, $urandom_range(0, 3) != 0);
        end
        len = $urandom_range(3, 10);
        for (int i = 0; i < len; i++) begin
          queue_word($urandom_range(0, 19) == 0, 2'($urandom_range(0, 3)), 1'b0, pid_sel,
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 3) != 0);
        end
      end else if (kind < 17) begin
        queue_word(1'b1, 2'($urandom_range(0, 3)), 1'b0, 2'($urandom_range(0, 3)),
                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) begin
          queue_word(1'b0, 2'($urandom_range(0, 3)), 1'b0, 2'($urandom_range(0, 3)),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
        end
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          raw = 16'($urandom);
          stim_words.push_back(in_t'(raw));
        end
      end
    end

    // Hold reset, then release it for good.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every word has gone in and every result has come back;
    // sample between edges so the driver and monitor have settled.
    while (stim_words.size() != 0 || in_valid) @(negedge clk);
    while (tx_words_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
